>>> design/clnwf_pkg.sv
// Shared types and constants for the character display nibble write formatter.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package clnwf_pkg;

	// Request kinds carried on func.
	typedef enum logic [1:0] {
		FUNC_CMD    = 2'd0,
		FUNC_DATA   = 2'd1,
		FUNC_NUMBER = 2'd2,
		FUNC_CURSOR = 2'd3
	} func_t;

	localparam int unsigned BIN_W      = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
	localparam int unsigned STEP_W     = $clog2(BIN_W);
	localparam int unsigned DIG_W      = $clog2(NUM_DIGITS);

	localparam logic [7:0] DDRAM_SET  = 8'h80;
	localparam logic [3:0] ASCII_ZERO_HI = 4'h3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic conv_step;
		logic drop_digit;
		logic emit_hi;
		logic emit_lo;
	} dp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic is_num;
		logic conv_done;
		logic top_zero;
		logic dig_last;
	} dp_status_t;

	function automatic logic [7:0] row_base(input logic [1:0] row);
		logic [7:0] base;
		case (row)
			2'd0:    base = 8'h00;
			2'd1:    base = 8'h40;
			2'd2:    base = 8'h14;
			2'd3:    base = 8'h54;
			default: base = 8'h00;
		endcase
		return base;
	endfunction

endpackage

>>> design/clnwf_ctrl.sv
// Controller state machine of the nibble write formatter.
// Depends on clnwf_pkg for the command and status structs.
`timescale 1ns / 1ps

module clnwf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [1:0]             func,
	input  clnwf_pkg::dp_status_t  status,
	output clnwf_pkg::dp_cmd_t     cmd,
	output logic                   busy
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_HIGH = 5'b01000,
		ST_LOW  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (func == clnwf_pkg::FUNC_NUMBER) begin
						state_d = ST_CONV;
					end else begin
						state_d = ST_HIGH;
					end
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (status.conv_done) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// Leading zeros are dropped, but the units digit always prints.
				if (status.top_zero && !status.dig_last) begin
					cmd.drop_digit = 1'b1;
				end else begin
					state_d = ST_HIGH;
				end
			end
			ST_HIGH: begin
				cmd.emit_hi = 1'b1;
				state_d     = ST_LOW;
			end
			ST_LOW: begin
				cmd.emit_lo = 1'b1;
				if (status.is_num && !status.dig_last) begin
					cmd.drop_digit = 1'b1;
					state_d        = ST_HIGH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> design/clnwf_datapath.sv
// Datapath of the nibble write formatter: request registers, binary to BCD
// converter and the registered beat output. Depends on clnwf_pkg.
`timescale 1ns / 1ps

module clnwf_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  clnwf_pkg::dp_cmd_t                  cmd,
	input  logic [1:0]                          func,
	input  logic [7:0]                          byte_value,
	input  logic [clnwf_pkg::BIN_W-1:0]         number_value,
	input  logic [1:0]                          row,
	input  logic [5:0]                          col,
	output clnwf_pkg::dp_status_t               status,
	output logic                                strobe,
	output logic                                reg_select,
	output logic [3:0]                          nibble,
	output logic                                last
);

	logic                            is_num_q;
	logic                            rs_q;
	logic [7:0]                      byte_q;
	logic [clnwf_pkg::BIN_W-1:0]     bin_q;
	logic [clnwf_pkg::BCD_W-1:0]     bcd_q;
	logic [clnwf_pkg::STEP_W-1:0]    step_q;
	logic [clnwf_pkg::DIG_W-1:0]     dig_q;
	logic [clnwf_pkg::BCD_W-1:0]     bcd_adj;
	logic [7:0]                      cur_byte;
	logic [7:0]                      cursor_addr;
	logic                            final_byte;

	// Add three to every digit of five or more before the shift.
	always_comb begin
		for (int i = 0; i < clnwf_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign cursor_addr = (clnwf_pkg::row_base(row) + {2'b00, col}) | clnwf_pkg::DDRAM_SET;
	assign cur_byte    = is_num_q ? {clnwf_pkg::ASCII_ZERO_HI,
		bcd_q[clnwf_pkg::BCD_W-1 -: 4]} : byte_q;
	assign final_byte  = !is_num_q || (dig_q == '0);

	assign status.is_num    = is_num_q;
	assign status.conv_done = (step_q == '0);
	assign status.top_zero  = (bcd_q[clnwf_pkg::BCD_W-1 -: 4] == 4'd0);
	assign status.dig_last  = (dig_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_num_q <= (func == clnwf_pkg::FUNC_NUMBER);
			rs_q     <= (func == clnwf_pkg::FUNC_DATA) || (func == clnwf_pkg::FUNC_NUMBER);
			byte_q   <= (func == clnwf_pkg::FUNC_CURSOR) ? cursor_addr : byte_value;
			bin_q    <= number_value;
			bcd_q    <= '0;
			step_q   <= clnwf_pkg::STEP_W'(clnwf_pkg::BIN_W - 1);
			dig_q    <= clnwf_pkg::DIG_W'(clnwf_pkg::NUM_DIGITS - 1);
		end else if (cmd.conv_step) begin
			bcd_q  <= {bcd_adj[clnwf_pkg::BCD_W-2:0], bin_q[clnwf_pkg::BIN_W-1]};
			bin_q  <= {bin_q[clnwf_pkg::BIN_W-2:0], 1'b0};
			step_q <= step_q - clnwf_pkg::STEP_W'(1);
		end else if (cmd.drop_digit) begin
			bcd_q <= {bcd_q[clnwf_pkg::BCD_W-5:0], 4'd0};
			dig_q <= dig_q - clnwf_pkg::DIG_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit_hi || cmd.emit_lo;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_hi) begin
			reg_select <= rs_q;
			nibble     <= cur_byte[7:4];
			last       <= 1'b0;
		end else if (cmd.emit_lo) begin
			reg_select <= rs_q;
			nibble     <= cur_byte[3:0];
			last       <= final_byte;
		end
	end

endmodule

>>> design/char_lcd_nibble_write_formatter.sv
// Top level of the character display nibble write formatter (4-bit bus).
// Instantiates clnwf_ctrl and clnwf_datapath; depends on clnwf_pkg.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  request  | start, busy          | func, byte_value, number_value, row, col
//  beat     | strobe (one cycle)   | reg_select, nibble, last
//
// A command, character or cursor move keeps busy high while its high and low
// nibble beats are formed; each beat is registered and shows in the cycle
// after it is formed. A number is first converted by shift-and-add-3 in the
// BCD converter, then a scan drops its leading zeros, then each digit goes
// out as a high and a low beat. Beats of one request come out in consecutive
// cycles. A new request can be taken while the final beat of the previous
// one is still on the outputs. Reset clears the controller and the strobe;
// the beat receiver cannot stall.
`timescale 1ns / 1ps

module char_lcd_nibble_write_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  byte_value,
	input  logic [31:0] number_value,
	input  logic [1:0]  row,
	input  logic [5:0]  col,
	output logic        strobe,
	output logic        reg_select,
	output logic [3:0]  nibble,
	output logic        last
);

	clnwf_pkg::dp_cmd_t    cmd;
	clnwf_pkg::dp_status_t status;

	clnwf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	clnwf_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.func         (func),
		.byte_value   (byte_value),
		.number_value (number_value),
		.row          (row),
		.col          (col),
		.status       (status),
		.strobe       (strobe),
		.reg_select   (reg_select),
		.nibble       (nibble),
		.last         (last)
	);

endmodule

>>> design/clnwf_checker.sv
// Port-level checker for the nibble write formatter, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module clnwf_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic last
);

	// Every request has at least two beats, so an accepted one keeps busy up.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted transaction");

	// Beats of one request are never separated by an idle cycle.
	a_beats_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap between beats of one transaction");

	// The final beat is shown once the controller is already free.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("busy still high on the final beat");

	// The block only goes idle as the final beat of a request appears.
	a_fell_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last)
		else $error("busy fell without a final beat");

endmodule

bind char_lcd_nibble_write_formatter clnwf_checker u_clnwf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.last   (last)
);

>>> bench/tb_char_lcd_nibble_write_formatter.sv
// Self-checking testbench for the character display nibble write formatter.
// Predicts every nibble beat of each request and compares it on the strobe.
// Depends on clnwf_pkg and char_lcd_nibble_write_formatter.
`timescale 1ns / 1ps

module tb_char_lcd_nibble_write_formatter;

	typedef struct packed {
		logic       rs;
		logic [3:0] nib;
		logic       fin;
	} beat_t;

	typedef struct packed {
		clnwf_pkg::func_t f;
		logic [7:0]       b;
		logic [31:0]      num;
		logic [1:0]       r;
		logic [5:0]       c;
		logic [3:0]       tlen;
		logic             trs;
		logic [79:0]      tchars;
	} request_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	clnwf_pkg::func_t func;
	logic [7:0]       byte_value;
	logic [31:0]      number_value;
	logic [1:0]       row;
	logic [5:0]       col;
	logic             strobe;
	logic             reg_select;
	logic [3:0]       nibble;
	logic             last;

	// Typed-in expectation travels with the request, registered like the ports.
	logic [3:0]  typed_len;
	logic        typed_rs;
	logic [79:0] typed_chars;

	beat_t        beats_due[$];
	request_row_t directed_rows[$];
	int           mismatches = 0;
	int           beats_checked = 0;
	int           requests_taken = 0;
	int           kind_count[4] = '{0, 0, 0, 0};

	char_lcd_nibble_write_formatter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.byte_value   (byte_value),
		.number_value (number_value),
		.row          (row),
		.col          (col),
		.strobe       (strobe),
		.reg_select   (reg_select),
		.nibble       (nibble),
		.last         (last)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 30) begin
			$display("MISMATCH at %0t ns: %s", $time, msg);
		end
	endtask

	function automatic void push_byte_beats(input logic rs, input logic [7:0] b,
			input logic fin);
		beats_due.push_back(beat_t'{rs: rs, nib: b[7:4], fin: 1'b0});
		beats_due.push_back(beat_t'{rs: rs, nib: b[3:0], fin: fin});
	endfunction

	function automatic logic [7:0] cursor_address(input logic [1:0] r, input logic [5:0] c);
		logic [7:0] base;
		case (r)
			2'd0: base = 8'h00;
			2'd1: base = 8'h40;
			2'd2: base = 8'h14;
			default: base = 8'h54;
		endcase
		return (base + {2'b00, c}) | 8'h80;
	endfunction

	function automatic void predict_request_beats(input clnwf_pkg::func_t f,
			input logic [7:0] b, input logic [31:0] num, input logic [1:0] r,
			input logic [5:0] c);
		logic [3:0]  digs[10];
		logic [31:0] v;
		int          n;
		case (f)
			clnwf_pkg::FUNC_CMD:  push_byte_beats(1'b0, b, 1'b1);
			clnwf_pkg::FUNC_DATA: push_byte_beats(1'b1, b, 1'b1);
			clnwf_pkg::FUNC_NUMBER: begin
				// Collect digits least significant first, then send them in reverse.
				v = num;
				n = 0;
				do begin
					digs[n] = 4'(v % 10);
					v = v / 10;
					n++;
				end while (v != 0 && n < 10);
				for (int i = n - 1; i >= 0; i--) begin
					push_byte_beats(1'b1, 8'h30 + {4'h0, digs[i]}, i == 0);
				end
			end
			default: push_byte_beats(1'b0, cursor_address(r, c), 1'b1);
		endcase
	endfunction

	always @(posedge clk) begin : beat_scoreboard
		beat_t exp_beat;
		if (arst_n) begin
			if (strobe) begin
				beats_checked++;
				if (beats_due.size() == 0) begin
					report_mismatch($sformatf("unexpected beat rs=%0b nibble=%h last=%0b",
						reg_select, nibble, last));
				end else begin
					exp_beat = beats_due.pop_front();
					if (reg_select !== exp_beat.rs)
						report_mismatch($sformatf("reg_select %0b, expected %0b",
							reg_select, exp_beat.rs));
					if (nibble !== exp_beat.nib)
						report_mismatch($sformatf("nibble %h, expected %h",
							nibble, exp_beat.nib));
					if (last !== exp_beat.fin)
						report_mismatch($sformatf("last %0b, expected %0b",
							last, exp_beat.fin));
				end
			end
			if (start && !busy) begin
				requests_taken++;
				kind_count[func]++;
				if (typed_len != 0) begin
					for (int i = 0; i < typed_len; i++) begin
						push_byte_beats(typed_rs, typed_chars[8 * (typed_len - 1 - i) +: 8],
							i == typed_len - 1);
					end
				end else begin
					predict_request_beats(func, byte_value, number_value, row, col);
				end
			end
		end
	end

	function automatic void add_row(input clnwf_pkg::func_t f, input logic [7:0] b,
			input logic [31:0] num, input logic [1:0] r, input logic [5:0] c,
			input logic [3:0] tlen, input logic trs, input logic [79:0] tchars);
		directed_rows.push_back(request_row_t'{f: f, b: b, num: num, r: r, c: c,
			tlen: tlen, trs: trs, tchars: tchars});
	endfunction

	function automatic logic [31:0] pick_number();
		logic [31:0] p;
		p = 32'd1;
		case ($urandom_range(7))
			0: begin
				repeat ($urandom_range(9)) p = p * 10;
				return p;
			end
			1: begin
				repeat ($urandom_range(9)) p = p * 10;
				return p - 1;
			end
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	// Holds start high until the request is taken; ports stay random while idle.
	task automatic issue_request(input int gap, input request_row_t rq);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) begin
				func         <= clnwf_pkg::func_t'($urandom_range(3));
				byte_value   <= 8'($urandom);
				number_value <= $urandom;
				row          <= 2'($urandom);
				col          <= 6'($urandom);
				typed_len    <= 4'd0;
				@(posedge clk);
			end
		end
		start        <= 1'b1;
		func         <= rq.f;
		byte_value   <= rq.b;
		number_value <= rq.num;
		row          <= rq.r;
		col          <= rq.c;
		typed_len    <= rq.tlen;
		typed_rs     <= rq.trs;
		typed_chars  <= rq.tchars;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_for_drain();
		int guard;
		guard = 0;
		start <= 1'b0;
		@(posedge clk);
		while (beats_due.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	task automatic run_phase(input int n, input int idle_pct);
		request_row_t rq;
		int           gap;
		for (int k = 0; k < n; k++) begin
			gap = 0;
			while (gap < 300 && $urandom_range(99) < idle_pct) gap++;
			// Now and then a long pause, so that gaps land deep inside a conversion.
			if (idle_pct > 0 && $urandom_range(9) == 0) gap += $urandom_range(70);
			rq.f      = clnwf_pkg::func_t'($urandom_range(3));
			rq.b      = 8'($urandom);
			rq.num    = pick_number();
			rq.r      = 2'($urandom);
			rq.c      = 6'($urandom);
			rq.tlen   = 4'd0;
			rq.trs    = 1'b0;
			rq.tchars = '0;
			issue_request(gap, rq);
		end
	endtask

	initial begin
		start        = 1'b0;
		func         = clnwf_pkg::FUNC_CMD;
		byte_value   = '0;
		number_value = '0;
		row          = '0;
		col          = '0;
		typed_len    = '0;
		typed_rs     = 1'b0;
		typed_chars  = '0;
		arst_n       = 1'b0;

		// Directed rows: a zero length means the predictor supplies the beats.
		add_row(clnwf_pkg::FUNC_CMD, 8'h00, 32'd0, 2'd0, 6'd0, 4'd1, 1'b0, 80'h00);
		add_row(clnwf_pkg::FUNC_CMD, 8'hFF, 32'd0, 2'd0, 6'd0, 4'd1, 1'b0, 80'hFF);
		add_row(clnwf_pkg::FUNC_DATA, 8'h00, 32'd0, 2'd0, 6'd0, 4'd1, 1'b1, 80'h00);
		add_row(clnwf_pkg::FUNC_DATA, 8'hFF, 32'hFFFF_FFFF, 2'd3, 6'd63, 4'd1, 1'b1, 80'hFF);
		add_row(clnwf_pkg::FUNC_DATA, 8'h41, 32'd0, 2'd0, 6'd0, 4'd0, 1'b0, 80'h0);
		add_row(clnwf_pkg::FUNC_CMD, 8'h01, 32'hFFFF_FFFF, 2'd3, 6'd63, 4'd0, 1'b0, 80'h0);
		add_row(clnwf_pkg::FUNC_NUMBER, 8'hFF, 32'd0, 2'd3, 6'd63, 4'd1, 1'b1, "0");
		add_row(clnwf_pkg::FUNC_NUMBER, 8'h00, 32'hFFFF_FFFF, 2'd0, 6'd0, 4'd10, 1'b1,
			"4294967295");
		add_row(clnwf_pkg::FUNC_NUMBER, 8'h00, 32'd9, 2'd0, 6'd0, 4'd1, 1'b1, "9");
		add_row(clnwf_pkg::FUNC_NUMBER, 8'h00, 32'd10, 2'd0, 6'd0, 4'd2, 1'b1, "10");
		add_row(clnwf_pkg::FUNC_NUMBER, 8'h00, 32'd100, 2'd0, 6'd0, 4'd3, 1'b1, "100");
		add_row(clnwf_pkg::FUNC_NUMBER, 8'h00, 32'd1000000000, 2'd0, 6'd0, 4'd10, 1'b1,
			"1000000000");
		add_row(clnwf_pkg::FUNC_NUMBER, 8'h00, 32'd999999999, 2'd0, 6'd0, 4'd0, 1'b0, 80'h0);
		add_row(clnwf_pkg::FUNC_NUMBER, 8'h00, 32'd99, 2'd0, 6'd0, 4'd0, 1'b0, 80'h0);
		add_row(clnwf_pkg::FUNC_NUMBER, 8'hA5, 32'd12345, 2'd2, 6'd17, 4'd0, 1'b0, 80'h0);
		add_row(clnwf_pkg::FUNC_CURSOR, 8'h00, 32'd0, 2'd0, 6'd0, 4'd1, 1'b0, 80'h80);
		add_row(clnwf_pkg::FUNC_CURSOR, 8'h00, 32'd0, 2'd1, 6'd0, 4'd1, 1'b0, 80'hC0);
		add_row(clnwf_pkg::FUNC_CURSOR, 8'h00, 32'd0, 2'd2, 6'd0, 4'd1, 1'b0, 80'h94);
		add_row(clnwf_pkg::FUNC_CURSOR, 8'hFF, 32'hFFFF_FFFF, 2'd3, 6'd0, 4'd1, 1'b0, 80'hD4);
		add_row(clnwf_pkg::FUNC_CURSOR, 8'h00, 32'd0, 2'd3, 6'd63, 4'd1, 1'b0, 80'h93);
		add_row(clnwf_pkg::FUNC_CURSOR, 8'h00, 32'd0, 2'd1, 6'd39, 4'd0, 1'b0, 80'h0);
		add_row(clnwf_pkg::FUNC_CURSOR, 8'h00, 32'd0, 2'd0, 6'd63, 4'd0, 1'b0, 80'h0);
		add_row(clnwf_pkg::FUNC_CURSOR, 8'h5A, 32'd77, 2'd2, 6'd40, 4'd0, 1'b0, 80'h0);
		add_row(clnwf_pkg::FUNC_NUMBER, 8'hFF, 32'd1, 2'd1, 6'd21, 4'd0, 1'b0, 80'h0);
		add_row(clnwf_pkg::FUNC_DATA, 8'h30, 32'd5, 2'd1, 6'd5, 4'd0, 1'b0, 80'h0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) issue_request(0, directed_rows[i]);
		wait_for_drain();

		run_phase(45, 0);
		wait_for_drain();
		run_phase(45, 74);
		wait_for_drain();
		run_phase(45, 12);
		wait_for_drain();

		// Any beat still outstanding here is lost; let stray beats show up too.
		repeat (80) @(posedge clk);
		if (beats_due.size() != 0) begin
			report_mismatch($sformatf("%0d expected beats never arrived", beats_due.size()));
		end

		$display("Covered %0d requests (cmd %0d, data %0d, number %0d, cursor %0d)",
			requests_taken, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
		$display("and %0d nibble beats, back to back and with random sender gaps.",
			beats_checked);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout: the run did not complete.");
		$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
design/clnwf_pkg.sv
design/clnwf_ctrl.sv
design/clnwf_datapath.sv
design/char_lcd_nibble_write_formatter.sv
design/clnwf_checker.sv
bench/tb_char_lcd_nibble_write_formatter.sv
